[hw/rtl/zbps_pkg.sv]
// Shared types, constants and the arithmetic step table of the z-buffered point shader.
package zbps_pkg;

  localparam logic [3:0] BLANK_CODE = 4'd12;
  localparam logic [3:0] MAX_CODE   = 4'd11;
  localparam logic [7:0] SPACE_CHAR = 8'h20;
  localparam int         NUM_UOPS   = 26;
  localparam int         DIV_STEPS  = 27;
  localparam int         PROJ_STEPS = 6;

  typedef enum logic {
    OP_PLOT = 1'b0,
    OP_READ = 1'b1
  } opcode_e;

  typedef enum logic [2:0] {
    CFG_COS_A     = 3'd0,
    CFG_SIN_A     = 3'd1,
    CFG_COS_B     = 3'd2,
    CFG_SIN_B     = 3'd3,
    CFG_TUBE_R    = 3'd4,
    CFG_RING_R    = 3'd5,
    CFG_VIEW_DIST = 3'd6,
    CFG_PROJ_SCL  = 3'd7
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MATH,
    ST_SAT,
    ST_DIV,
    ST_PROJ,
    ST_CHECK,
    ST_READ
  } state_e;

  typedef enum logic [3:0] {
    SRC_R1, SRC_CT, SRC_ST, SRC_CP, SRC_SP, SRC_CA, SRC_SA,
    SRC_CB, SRC_SB, SRC_CX, SRC_CY, SRC_T0, SRC_T1
  } src_e;

  typedef enum logic [1:0] {
    ADD_ZERO, ADD_R2, ADD_K2, ADD_DST
  } add_e;

  typedef enum logic [2:0] {
    DST_CX, DST_CY, DST_T0, DST_T1, DST_X, DST_Y, DST_Z, DST_LUM
  } dst_e;

  typedef struct packed {
    src_e a;
    src_e b;
    add_e add;
    logic sub;
    dst_e dst;
  } uop_t;

  function automatic uop_t mk(src_e a, src_e b, add_e add, logic sub, dst_e dst);
    uop_t u;
    u.a   = a;
    u.b   = b;
    u.add = add;
    u.sub = sub;
    u.dst = dst;
    return u;
  endfunction

  function automatic uop_t uop(logic [4:0] step);
    uop_t u;
    case (step)
      5'd0:    u = mk(SRC_R1, SRC_CT, ADD_R2,   1'b0, DST_CX);
      5'd1:    u = mk(SRC_R1, SRC_ST, ADD_ZERO, 1'b0, DST_CY);
      5'd2:    u = mk(SRC_SA, SRC_SB, ADD_ZERO, 1'b0, DST_T1);
      5'd3:    u = mk(SRC_CB, SRC_CP, ADD_ZERO, 1'b0, DST_T0);
      5'd4:    u = mk(SRC_T1, SRC_SP, ADD_DST,  1'b0, DST_T0);
      5'd5:    u = mk(SRC_CX, SRC_T0, ADD_ZERO, 1'b0, DST_X);
      5'd6:    u = mk(SRC_CA, SRC_SB, ADD_ZERO, 1'b0, DST_T1);
      5'd7:    u = mk(SRC_CY, SRC_T1, ADD_DST,  1'b1, DST_X);
      5'd8:    u = mk(SRC_SA, SRC_CB, ADD_ZERO, 1'b0, DST_T1);
      5'd9:    u = mk(SRC_SB, SRC_CP, ADD_ZERO, 1'b0, DST_T0);
      5'd10:   u = mk(SRC_T1, SRC_SP, ADD_DST,  1'b1, DST_T0);
      5'd11:   u = mk(SRC_CX, SRC_T0, ADD_ZERO, 1'b0, DST_Y);
      5'd12:   u = mk(SRC_CA, SRC_CB, ADD_ZERO, 1'b0, DST_T1);
      5'd13:   u = mk(SRC_CY, SRC_T1, ADD_DST,  1'b0, DST_Y);
      5'd14:   u = mk(SRC_CA, SRC_CX, ADD_ZERO, 1'b0, DST_T0);
      5'd15:   u = mk(SRC_T0, SRC_SP, ADD_K2,   1'b0, DST_Z);
      5'd16:   u = mk(SRC_CY, SRC_SA, ADD_DST,  1'b0, DST_Z);
      5'd17:   u = mk(SRC_CP, SRC_CT, ADD_ZERO, 1'b0, DST_T0);
      5'd18:   u = mk(SRC_T0, SRC_SB, ADD_ZERO, 1'b0, DST_LUM);
      5'd19:   u = mk(SRC_CA, SRC_CT, ADD_ZERO, 1'b0, DST_T0);
      5'd20:   u = mk(SRC_T0, SRC_SP, ADD_DST,  1'b1, DST_LUM);
      5'd21:   u = mk(SRC_SA, SRC_ST, ADD_DST,  1'b1, DST_LUM);
      5'd22:   u = mk(SRC_CT, SRC_SA, ADD_ZERO, 1'b0, DST_T0);
      5'd23:   u = mk(SRC_CA, SRC_ST, ADD_ZERO, 1'b0, DST_T1);
      5'd24:   u = mk(SRC_T0, SRC_SP, ADD_DST,  1'b1, DST_T1);
      5'd25:   u = mk(SRC_CB, SRC_T1, ADD_DST,  1'b0, DST_LUM);
      default: u = mk(SRC_R1, SRC_R1, ADD_ZERO, 1'b0, DST_T0);
    endcase
    return u;
  endfunction

  function automatic logic [7:0] shade_char(logic [3:0] code);
    logic [7:0] c;
    case (code)
      4'd0:    c = ".";
      4'd1:    c = ",";
      4'd2:    c = "-";
      4'd3:    c = "~";
      4'd4:    c = ":";
      4'd5:    c = ";";
      4'd6:    c = "=";
      4'd7:    c = "!";
      4'd8:    c = "*";
      4'd9:    c = "#";
      4'd10:   c = "$";
      4'd11:   c = "@";
      default: c = SPACE_CHAR;
    endcase
    return c;
  endfunction

endpackage

[hw/rtl/zbuffer_point_shader.sv]
// Z-buffered torus point shader: shared-multiplier sequencer, divider and frame store.
// Plot item: 26 multiply steps, saturate, 27 divide steps, 6 projection steps, check,
//   store update; no update if off screen or unlit, nothing after saturate if behind viewer.
// Read item: busy in ST_READ, then strobe; out-of-range read: strobe set from idle, no busy.
// Results cannot be stalled: each is on the ports for one cycle with result_valid_o.
// After reset the frame store is cleared, one cell a cycle, and busy stays high until every cell is blank.
module zbuffer_point_shader #(
  parameter int SCREEN_SIZE        = 32,
  parameter int TRIG_FRACTION_BITS = 14
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_idx_i,
  input  logic [15:0]        cfg_data_i,
  input  logic               opcode_i,
  input  logic signed [15:0] cos_theta_i,
  input  logic signed [15:0] sin_theta_i,
  input  logic signed [15:0] cos_phi_i,
  input  logic signed [15:0] sin_phi_i,
  input  logic [7:0]         cell_row_i,
  input  logic [7:0]         cell_col_i,
  output logic [7:0]         cell_char_o,
  output logic               cell_lit_o,
  output logic               result_valid_o
);
  import zbps_pkg::*;

  localparam int CELLS = SCREEN_SIZE * SCREEN_SIZE;
  localparam int AW    = $clog2(CELLS);
  localparam int CW    = $clog2(SCREEN_SIZE);
  localparam int F     = TRIG_FRACTION_BITS;
  localparam int TW    = 48;
  localparam int PW    = 40;
  localparam int MW    = 36;
  localparam logic [AW-1:0] S_A = AW'(SCREEN_SIZE);
  localparam logic signed [TW-1:0] LIM = TW'(64'sd16777216);

  state_e state_q, state_d;
  logic [4:0]    step_q, step_d;
  logic [2:0]    pstep_q, pstep_d;
  logic [4:0]    cnt_q, cnt_d;
  logic [AW-1:0] clr_q, clr_d;
  logic          vld_q, vld_d;
  logic [7:0]    char_q, char_d;
  logic          lit_q, lit_d;

  logic signed [15:0] ca_q, sa_q, cb_q, sb_q;
  logic [15:0]        r1_q, r2_q, k2_q, k1_q;

  logic               op_q;
  logic signed [15:0] ct_q, st_q, cp_q, sp_q;
  logic signed [TW-1:0] cx_q, cy_q, t0_q, t1_q, x_q, y_q, z_q, lum_q;
  logic signed [MW-1:0] mx_q, my_q;
  logic signed [63:0]   pacc_q;
  logic signed [PW-1:0] coff_q, roff_q;
  logic [24:0]   rem_q;
  logic [26:0]   quo_q;
  logic [AW-1:0] idx_q;

  logic          ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [19:0]   ram_wdata, ram_rdata;

  uop_t u;
  logic signed [31:0]   mul_a, mul_b;
  logic signed [63:0]   prod;
  logic signed [TW-1:0] qp, addv, dstv, mac;
  logic signed [PW-1:0] colv, rowv;
  logic          pt_ok, in_rng;
  logic [AW-1:0] pt_idx, in_idx;
  logic [25:0]   div_r;
  logic          div_ge;
  logic [24:0]   div_rem;
  logic [15:0]   depth_v;
  logic signed [TW-1:0] codew;
  logic [3:0]    code_v;

  function automatic logic signed [31:0] pick(src_e s);
    logic signed [31:0] v;
    case (s)
      SRC_R1:  v = signed'({16'd0, r1_q});
      SRC_CT:  v = 32'(ct_q);
      SRC_ST:  v = 32'(st_q);
      SRC_CP:  v = 32'(cp_q);
      SRC_SP:  v = 32'(sp_q);
      SRC_CA:  v = 32'(ca_q);
      SRC_SA:  v = 32'(sa_q);
      SRC_CB:  v = 32'(cb_q);
      SRC_SB:  v = 32'(sb_q);
      SRC_CX:  v = signed'(cx_q[31:0]);
      SRC_CY:  v = signed'(cy_q[31:0]);
      SRC_T0:  v = signed'(t0_q[31:0]);
      SRC_T1:  v = signed'(t1_q[31:0]);
      default: v = '0;
    endcase
    return v;
  endfunction

  function automatic logic signed [TW-1:0] sat(logic signed [TW-1:0] v);
    logic signed [TW-1:0] r;
    if (v > LIM) begin
      r = LIM;
    end else if (v < -LIM) begin
      r = -LIM;
    end else begin
      r = v;
    end
    return r;
  endfunction

  assign u = uop(step_q);

  always_comb begin
    mul_a = pick(u.a);
    mul_b = pick(u.b);
    if (state_q == ST_PROJ) begin
      case (pstep_q)
        3'd0: begin
          mul_a = signed'({16'd0, k1_q});
          mul_b = signed'(x_q[31:0]);
        end
        3'd1: begin
          mul_a = signed'({16'd0, k1_q});
          mul_b = signed'(y_q[31:0]);
        end
        3'd2: begin
          mul_a = signed'({15'd0, mx_q[16:0]});
          mul_b = signed'({5'd0, quo_q});
        end
        3'd3: begin
          mul_a = signed'({{13{mx_q[MW-1]}}, mx_q[MW-1:17]});
          mul_b = signed'({5'd0, quo_q});
        end
        3'd4: begin
          mul_a = signed'({15'd0, my_q[16:0]});
          mul_b = signed'({5'd0, quo_q});
        end
        default: begin
          mul_a = signed'({{13{my_q[MW-1]}}, my_q[MW-1:17]});
          mul_b = signed'({5'd0, quo_q});
        end
      endcase
    end
  end

  assign prod = 64'(mul_a) * 64'(mul_b);
  assign qp   = TW'(prod >>> F);

  always_comb begin
    case (u.dst)
      DST_CX:  dstv = cx_q;
      DST_CY:  dstv = cy_q;
      DST_T0:  dstv = t0_q;
      DST_T1:  dstv = t1_q;
      DST_X:   dstv = x_q;
      DST_Y:   dstv = y_q;
      DST_Z:   dstv = z_q;
      default: dstv = lum_q;
    endcase
    case (u.add)
      ADD_ZERO: addv = '0;
      ADD_R2:   addv = signed'({32'd0, r2_q});
      ADD_K2:   addv = signed'({32'd0, k2_q});
      default:  addv = dstv;
    endcase
    mac = u.sub ? addv - qp : addv + qp;
  end

  assign div_r   = {rem_q, (cnt_q == 5'(DIV_STEPS - 1))};
  assign div_ge  = div_r >= {1'b0, z_q[24:0]};
  assign div_rem = div_ge ? 25'(div_r - {1'b0, z_q[24:0]}) : div_r[24:0];

  assign colv   = PW'(SCREEN_SIZE / 2) + coff_q;
  assign rowv   = PW'(SCREEN_SIZE / 2) - roff_q;
  assign pt_ok  = (colv >= 0) && (colv < PW'(SCREEN_SIZE)) && (rowv >= 0) &&
                  (rowv < PW'(SCREEN_SIZE)) && (lum_q > 0);
  assign pt_idx = AW'(AW'(rowv[CW-1:0]) * S_A) + AW'(colv[CW-1:0]);
  assign in_rng = ({1'b0, cell_row_i} < 9'(SCREEN_SIZE)) &&
                  ({1'b0, cell_col_i} < 9'(SCREEN_SIZE));
  assign in_idx = AW'(AW'(cell_row_i[CW-1:0]) * S_A) + AW'(cell_col_i[CW-1:0]);

  assign depth_v = (quo_q > 27'd65535) ? 16'hFFFF : quo_q[15:0];
  assign codew   = lum_q >>> (F - 3);
  assign code_v  = (codew > TW'(MAX_CODE)) ? MAX_CODE : codew[3:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      step_q  <= '0;
      pstep_q <= '0;
      cnt_q   <= '0;
      clr_q   <= '0;
      vld_q   <= 1'b0;
      char_q  <= SPACE_CHAR;
      lit_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      pstep_q <= pstep_d;
      cnt_q   <= cnt_d;
      clr_q   <= clr_d;
      vld_q   <= vld_d;
      char_q  <= char_d;
      lit_q   <= lit_d;
    end
  end

  always_comb begin
    state_d   = state_q;
    step_d    = step_q;
    pstep_d   = pstep_q;
    cnt_d     = cnt_q;
    clr_d     = clr_q;
    vld_d     = 1'b0;
    char_d    = char_q;
    lit_d     = lit_q;
    ram_we    = 1'b0;
    ram_waddr = idx_q;
    ram_wdata = {16'd0, BLANK_CODE};
    ram_raddr = idx_q;
    case (state_q)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_q;
        if (clr_q == AW'(CELLS - 1)) begin
          state_d = ST_IDLE;
        end else begin
          clr_d = clr_q + 1'b1;
        end
      end
      ST_IDLE: begin
        ram_raddr = in_idx;
        if (start) begin
          if (opcode_i == OP_READ) begin
            if (in_rng) begin
              state_d = ST_READ;
            end else begin
              vld_d  = 1'b1;
              char_d = SPACE_CHAR;
              lit_d  = 1'b0;
            end
          end else begin
            state_d = ST_MATH;
            step_d  = '0;
          end
        end
      end
      ST_MATH: begin
        if (step_q == 5'(NUM_UOPS - 1)) begin
          state_d = ST_SAT;
        end else begin
          step_d = step_q + 1'b1;
        end
      end
      ST_SAT: begin
        if (z_q <= 0) begin
          state_d = ST_IDLE;
        end else begin
          state_d = ST_DIV;
          cnt_d   = 5'(DIV_STEPS - 1);
        end
      end
      ST_DIV: begin
        if (cnt_q == 5'd0) begin
          state_d = ST_PROJ;
          pstep_d = '0;
        end else begin
          cnt_d = cnt_q - 1'b1;
        end
      end
      ST_PROJ: begin
        if (pstep_q == 3'(PROJ_STEPS - 1)) begin
          state_d = ST_CHECK;
        end else begin
          pstep_d = pstep_q + 1'b1;
        end
      end
      ST_CHECK: begin
        ram_raddr = pt_idx;
        state_d   = pt_ok ? ST_READ : ST_IDLE;
      end
      ST_READ: begin
        state_d = ST_IDLE;
        if (op_q == OP_READ) begin
          ram_we = 1'b1;
          vld_d  = 1'b1;
          lit_d  = ram_rdata[3:0] < BLANK_CODE;
          char_d = (ram_rdata[3:0] < BLANK_CODE) ? shade_char(ram_rdata[3:0]) : SPACE_CHAR;
        end else if (depth_v > ram_rdata[19:4]) begin
          ram_we    = 1'b1;
          ram_wdata = {depth_v, code_v};
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ca_q <= 16'sd8852;
      sa_q <= 16'sd13787;
      cb_q <= 16'sd8852;
      sb_q <= 16'sd13787;
      r1_q <= 16'd1024;
      r2_q <= 16'd2048;
      k2_q <= 16'd5120;
      k1_q <= 16'd5600;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_COS_A:     ca_q <= signed'(cfg_data_i);
        CFG_SIN_A:     sa_q <= signed'(cfg_data_i);
        CFG_COS_B:     cb_q <= signed'(cfg_data_i);
        CFG_SIN_B:     sb_q <= signed'(cfg_data_i);
        CFG_TUBE_R:    r1_q <= cfg_data_i;
        CFG_RING_R:    r2_q <= cfg_data_i;
        CFG_VIEW_DIST: k2_q <= cfg_data_i;
        CFG_PROJ_SCL:  k1_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        op_q  <= opcode_i;
        ct_q  <= cos_theta_i;
        st_q  <= sin_theta_i;
        cp_q  <= cos_phi_i;
        sp_q  <= sin_phi_i;
        idx_q <= in_idx;
      end
      ST_MATH: begin
        case (u.dst)
          DST_CX:  cx_q  <= mac;
          DST_CY:  cy_q  <= mac;
          DST_T0:  t0_q  <= mac;
          DST_T1:  t1_q  <= mac;
          DST_X:   x_q   <= mac;
          DST_Y:   y_q   <= mac;
          DST_Z:   z_q   <= mac;
          default: lum_q <= mac;
        endcase
      end
      ST_SAT: begin
        x_q   <= sat(x_q);
        y_q   <= sat(y_q);
        z_q   <= sat(z_q);
        rem_q <= '0;
        quo_q <= '0;
      end
      ST_DIV: begin
        rem_q <= div_rem;
        quo_q <= {quo_q[25:0], div_ge};
      end
      ST_PROJ: begin
        case (pstep_q)
          3'd0:    mx_q   <= MW'(prod >>> 8);
          3'd1:    my_q   <= MW'(prod >>> 8);
          3'd2:    pacc_q <= prod;
          3'd3:    coff_q <= PW'((pacc_q + (prod <<< 17)) >>> 26);
          3'd4:    pacc_q <= prod;
          default: roff_q <= PW'((pacc_q + (prod <<< 17)) >>> 26);
        endcase
      end
      ST_CHECK: idx_q <= pt_idx;
      default: ;
    endcase
  end

  zbps_ram #(
    .WIDTH(20),
    .DEPTH(CELLS)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign busy           = state_q != ST_IDLE;
  assign result_valid_o = vld_q;
  assign cell_char_o    = char_q;
  assign cell_lit_o     = lit_q;

  a_lit_char: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && cell_lit_o |-> cell_char_o != SPACE_CHAR)
    else $error("lit cell reads as blank");

  a_we_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (state_q == ST_CLEAR) || (state_q == ST_READ))
    else $error("store written outside clear or update");

  a_plot_wr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_READ) && (op_q == OP_PLOT) && ram_we |->
      (ram_wdata[3:0] <= MAX_CODE) && (ram_wdata[19:4] != 16'd0))
    else $error("bad plot write");

  a_vld_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(state_q == ST_READ) ||
      ($past(start) && $past(state_q == ST_IDLE)))
    else $error("result without a read item");

  a_div_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV) |=> ((state_q == ST_DIV) && (cnt_q == $past(cnt_q) - 5'd1)) ||
      (state_q == ST_PROJ))
    else $error("divider count slip");

endmodule

[hw/rtl/zbps_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module zbps_ram #(
  parameter int WIDTH = 20,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[test/zbuffer_point_shader_tb.sv]
// Self-checking testbench for the z-buffered torus point shader: plots, reads and register phases.
`timescale 1ns / 1ps

module zbuffer_point_shader_tb;
  import zbps_pkg::*;

  localparam int SCREEN   = 32;
  localparam int FRAC     = 14;
  localparam int CELLS    = SCREEN * SCREEN;
  localparam longint LIM  = 64'sd16777216;
  localparam int MAX_CYC  = 2000000;

  typedef struct {
    opcode_e             op;
    logic signed [15:0]  ct, st, cp, sp;
    logic [7:0]          row, col;
  } shader_item_t;

  typedef struct {
    logic [7:0] ch;
    logic       lit;
  } cell_read_t;

  class shade_board;
    logic [15:0] depth_mem [CELLS];
    logic [3:0]  code_mem [CELLS];
    logic [15:0] regs [8];
    cell_read_t  pending_cells [$];
    int          errors;

    function new();
      foreach (depth_mem[i]) begin
        depth_mem[i] = '0;
        code_mem[i]  = BLANK_CODE;
      end
      regs = '{16'd8852, 16'd13787, 16'd8852, 16'd13787, 16'd1024, 16'd2048, 16'd5120,
               16'd5600};
      errors = 0;
    endfunction

    function void set_reg(cfg_idx_e idx, logic [15:0] val);
      regs[idx] = val;
    endfunction

    function longint fmul(longint a, longint b);
      return (a * b) >>> FRAC;
    endfunction

    function longint clamp(longint v);
      if (v > LIM) return LIM;
      if (v < -LIM) return -LIM;
      return v;
    endfunction

    function void plot_sample(shader_item_t it);
      longint ca, sa, cb, sb, r1, r2, k2, k1, ct, st, cp, sp;
      longint cx, cy, x, y, z, lum, recip, row, col, code, dep;
      int idx;
      ca = longint'($signed(regs[CFG_COS_A]));
      sa = longint'($signed(regs[CFG_SIN_A]));
      cb = longint'($signed(regs[CFG_COS_B]));
      sb = longint'($signed(regs[CFG_SIN_B]));
      r1 = longint'(regs[CFG_TUBE_R]);
      r2 = longint'(regs[CFG_RING_R]);
      k2 = longint'(regs[CFG_VIEW_DIST]);
      k1 = longint'(regs[CFG_PROJ_SCL]);
      ct = it.ct; st = it.st; cp = it.cp; sp = it.sp;
      cx = r2 + fmul(r1, ct);
      cy = fmul(r1, st);
      x = fmul(cx, fmul(cb, cp) + fmul(fmul(sa, sb), sp)) - fmul(cy, fmul(ca, sb));
      y = fmul(cx, fmul(sb, cp) - fmul(fmul(sa, cb), sp)) + fmul(cy, fmul(ca, cb));
      z = k2 + fmul(fmul(ca, cx), sp) + fmul(cy, sa);
      x = clamp(x);
      y = clamp(y);
      z = clamp(z);
      if (z <= 0) return;
      recip = (64'sd1 <<< 26) / z;
      col = SCREEN / 2 + ((((k1 * x) >>> 8) * recip) >>> 26);
      row = SCREEN / 2 - ((((k1 * y) >>> 8) * recip) >>> 26);
      if (col < 0 || col >= SCREEN || row < 0 || row >= SCREEN) return;
      lum = fmul(fmul(cp, ct), sb) - fmul(fmul(ca, ct), sp) - fmul(sa, st)
          + fmul(cb, fmul(ca, st) - fmul(fmul(ct, sa), sp));
      if (lum <= 0) return;
      dep = (recip > 65535) ? 65535 : recip;
      idx = int'(row) * SCREEN + int'(col);
      if (dep <= longint'(depth_mem[idx])) return;
      code = lum >>> (FRAC - 3);
      if (code > 11) code = 11;
      depth_mem[idx] = dep[15:0];
      code_mem[idx]  = code[3:0];
    endfunction

    function void note(shader_item_t it);
      cell_read_t r;
      int idx;
      if (it.op == OP_PLOT) begin
        plot_sample(it);
        return;
      end
      r.ch  = SPACE_CHAR;
      r.lit = 1'b0;
      if (it.row < SCREEN && it.col < SCREEN) begin
        idx = int'(it.row) * SCREEN + int'(it.col);
        if (code_mem[idx] < BLANK_CODE) begin
          r.ch  = shade_char(code_mem[idx]);
          r.lit = 1'b1;
        end
        depth_mem[idx] = '0;
        code_mem[idx]  = BLANK_CODE;
      end
      pending_cells.push_back(r);
    endfunction

    function void check(logic [7:0] ch, logic lit);
      cell_read_t e;
      if (pending_cells.size() == 0) begin
        $error("unexpected result: cell_char %h cell_lit %b", ch, lit);
        errors++;
        return;
      end
      e = pending_cells.pop_front();
      if (ch !== e.ch) begin
        $error("cell_char: expected %h, actual %h", e.ch, ch);
        errors++;
      end
      if (lit !== e.lit) begin
        $error("cell_lit: expected %b, actual %b", e.lit, lit);
        errors++;
      end
    endfunction
  endclass

  logic               clk_i, rst_ni, start, busy;
  logic               cfg_we_i;
  logic [2:0]         cfg_idx_i;
  logic [15:0]        cfg_data_i;
  logic               opcode_i;
  logic signed [15:0] cos_theta_i, sin_theta_i, cos_phi_i, sin_phi_i;
  logic [7:0]         cell_row_i, cell_col_i;
  logic [7:0]         cell_char_o;
  logic               cell_lit_o, result_valid_o;

  shade_board board;
  bit         idle_on;
  int         cycles;

  zbuffer_point_shader i_dut (
    .clk_i, .rst_ni, .start, .busy, .cfg_we_i, .cfg_idx_i, .cfg_data_i, .opcode_i,
    .cos_theta_i, .sin_theta_i, .cos_phi_i, .sin_phi_i, .cell_row_i, .cell_col_i,
    .cell_char_o, .cell_lit_o, .result_valid_o
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > MAX_CYC) begin
      $display("zbuffer_point_shader_tb failed");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o) board.check(cell_char_o, cell_lit_o);
  end

  function automatic logic signed [15:0] trig(real v);
    return 16'($rtoi(v * 16384.0));
  endfunction

  function automatic shader_item_t plot_at(real th, real ph);
    shader_item_t it;
    it.op = OP_PLOT;
    it.ct = trig($cos(th)); it.st = trig($sin(th));
    it.cp = trig($cos(ph)); it.sp = trig($sin(ph));
    it.row = 8'($urandom); it.col = 8'($urandom);
    return it;
  endfunction

  function automatic shader_item_t read_at(logic [7:0] r, logic [7:0] c);
    shader_item_t it;
    it.op = OP_READ;
    it.ct = 16'($urandom); it.st = 16'($urandom);
    it.cp = 16'($urandom); it.sp = 16'($urandom);
    it.row = r; it.col = c;
    return it;
  endfunction

  function automatic shader_item_t raw_plot();
    shader_item_t it;
    it = read_at(8'($urandom), 8'($urandom));
    it.op = OP_PLOT;
    return it;
  endfunction

  function automatic shader_item_t random_item();
    int pick;
    real th, ph;
    pick = $urandom_range(99);
    th = 6.2831853 * $urandom_range(0, 9999) / 10000.0;
    ph = 6.2831853 * $urandom_range(0, 9999) / 10000.0;
    if (pick < 60) return plot_at(th, ph);
    if (pick < 68) return raw_plot();
    if (pick < 95) return read_at(8'($urandom_range(0, SCREEN - 1)),
                                  8'($urandom_range(0, SCREEN - 1)));
    return read_at(8'($urandom), 8'($urandom));
  endfunction

  task automatic send(shader_item_t it);
    if (idle_on && $urandom_range(99) < 15) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 5)) @(negedge clk_i);
    end
    start       <= 1'b1;
    opcode_i    <= it.op;
    cos_theta_i <= it.ct;
    sin_theta_i <= it.st;
    cos_phi_i   <= it.cp;
    sin_phi_i   <= it.sp;
    cell_row_i  <= it.row;
    cell_col_i  <= it.col;
    do @(posedge clk_i); while (busy);
    board.note(it);
    @(negedge clk_i);
  endtask

  task automatic drain();
    start <= 1'b0;
    @(negedge clk_i);
    while (busy || board.pending_cells.size() != 0) @(negedge clk_i);
    repeat (80) @(negedge clk_i);
  endtask

  task automatic load_regs(logic [15:0] v [8]);
    for (int i = 0; i < 8; i++) begin
      cfg_we_i   <= 1'b1;
      cfg_idx_i  <= 3'(i);
      cfg_data_i <= v[i];
      board.set_reg(cfg_idx_e'(i), v[i]);
      @(negedge clk_i);
    end
    cfg_we_i <= 1'b0;
  endtask

  task automatic scan_reads();
    for (int r = 0; r < SCREEN; r += 4)
      for (int c = 0; c < SCREEN; c += 4) send(read_at(8'(r), 8'(c)));
  endtask

  initial begin
    logic [15:0] v [8];
    real a, b;
    board = new();
    cycles = 0;
    idle_on = 1'b1;
    rst_ni = 1'b0;
    start = 1'b0;
    cfg_we_i = 1'b0; cfg_idx_i = '0; cfg_data_i = '0;
    opcode_i = OP_PLOT;
    cos_theta_i = '0; sin_theta_i = '0; cos_phi_i = '0; sin_phi_i = '0;
    cell_row_i = '0; cell_col_i = '0;
    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: blank read, out-of-range reads, extremes, repeated point, last-column read
    send(read_at(8'd0, 8'd0));
    send(read_at(8'd255, 8'd0));
    send(read_at(8'd0, 8'd255));
    send(read_at(8'd32, 8'd31));
    send(plot_at(0.0, 0.0));
    send(plot_at(0.0, 0.0));
    send(plot_at(3.14159, 1.5708));
    send(plot_at(1.0, 4.0));
    send(read_at(8'($urandom_range(0, 31)), 8'd31));
    send(raw_plot());
    begin
      shader_item_t it;
      it = plot_at(0.0, 0.0);
      it.ct = 16'sd16384; it.st = 16'sd16384; it.cp = -16'sd16384; it.sp = 16'sd16384;
      send(it);
      it.ct = -16'sd16384; it.st = -16'sd16384; it.cp = 16'sd16384; it.sp = -16'sd16384;
      send(it);
      it.ct = 16'sh7fff; it.st = 16'sh8000; it.cp = 16'sh7fff; it.sp = 16'sh8000;
      send(it);
    end
    scan_reads();

    for (int ph = 0; ph < 6; ph++) begin
      drain();
      case (ph)
        0: v = '{16'd16384, 16'd0, 16'd16384, 16'd0, 16'd1024, 16'd2048, 16'd5120,
                 16'd5600};
        1: v = '{-16'sd16384, -16'sd16384, -16'sd16384, -16'sd16384, 16'd65535,
                 16'd65535, 16'd0, 16'd65535};
        2: v = '{16'd0, 16'd16384, 16'd0, -16'sd16384, 16'd0, 16'd0, 16'd65535, 16'd0};
        default: begin
          a = 6.2831853 * $urandom_range(0, 999) / 1000.0;
          b = 6.2831853 * $urandom_range(0, 999) / 1000.0;
          v = '{trig($cos(a)), trig($sin(a)), trig($cos(b)), trig($sin(b)),
                16'($urandom_range(512, 1536)), 16'($urandom_range(1536, 3072)),
                16'($urandom_range(4096, 8192)), 16'($urandom_range(3000, 9000))};
        end
      endcase
      load_regs(v);
      idle_on = (ph != 3);
      for (int n = 0; n < 115; n++) send(random_item());
      scan_reads();
    end

    drain();
    if (board.errors == 0 && board.pending_cells.size() == 0) begin
      $display("zbuffer_point_shader_tb passed");
    end else begin
      $display("zbuffer_point_shader_tb failed");
    end
    $finish;
  end

endmodule

[files.f]
hw/rtl/zbps_pkg.sv
hw/rtl/zbps_ram.sv
hw/rtl/zbuffer_point_shader.sv
test/zbuffer_point_shader_tb.sv
